/* hdl/rlsf_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlsf_pkg
// Shared types and constants of the ring list segment-to-front unit.
// ----------------------------------------------------------------------------
package rlsf_pkg;

  localparam int unsigned VAL_W         = 11;
  localparam int unsigned ACT_W         = 2;
  localparam int unsigned DATA_W        = 32;
  localparam int unsigned ADDR_W        = 3;
  localparam int unsigned MAX_ITEMS_DEF = 1024;
  localparam int unsigned VAL_MAX       = (1 << VAL_W) - 1;

  localparam logic [VAL_W-1:0] LIST_SIZE_RST = VAL_W'(1024);
  localparam logic [VAL_W-1:0] VAL_ONE       = VAL_W'(1);

  // action codes
  localparam logic [ACT_W-1:0] ACT_BUILD = 2'd0;
  localparam logic [ACT_W-1:0] ACT_MOVE  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_WALK  = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NOP   = 2'd3;

  // register index (paddr word bit)
  localparam logic REG_LIST_SIZE = 1'b0;

  typedef struct packed {
    logic accept;
    logic bld_start;
    logic bld_wr;
    logic cur_head;
    logic mv_rd;
    logic mv_w1;
    logic mv_w2;
    logic mv_w3;
    logic wk_rd;
    logic res_load;
    logic res_walk;
    logic res_skip;
  } cmd_t;

  typedef struct packed {
    logic mv_ok;
    logic mv_head;
    logic bld_last;
  } sts_t;

endpackage

/* hdl/ring_list_segment_to_front_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_list_segment_to_front_unit
// Circular doubly linked ring of values 1..n with build, move-run-to-front
// and walk operations.
// ----------------------------------------------------------------------------
// One word is processed at a time; the result word sits in an output
// register, so the next word is taken while a result still waits. A walk
// reads one pointer; a skipped or out-of-range move and the unused action
// go straight to the result; build fills the clamped list size (1 to the
// lesser of MAX_ITEMS and VAL_MAX) of entries. Move and build time is set
// by the single write port of each pointer table (a read, then six pointer
// writes over W1 to W3); build writes one table entry pair per cycle.
module ring_list_segment_to_front_unit #(
  parameter int unsigned MAX_ITEMS = rlsf_pkg::MAX_ITEMS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [rlsf_pkg::ACT_W-1:0]  in_action,
  input  logic [rlsf_pkg::VAL_W-1:0]  in_first_value,
  input  logic [rlsf_pkg::VAL_W-1:0]  in_last_value,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [rlsf_pkg::VAL_W-1:0]  out_value,
  output logic                        out_is_last,
  output logic                        out_skipped,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [rlsf_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [rlsf_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [rlsf_pkg::DATA_W-1:0] cfg_prdata,
  output logic                        cfg_pready
);
  import rlsf_pkg::*;

  logic [VAL_W-1:0] list_size_r, list_size_nxt;
  logic             cfg_wr;
  cmd_t             cmd;
  sts_t             sts;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite &&
                      (cfg_paddr[2] == REG_LIST_SIZE);
  assign list_size_nxt = cfg_wr ? cfg_pwdata[VAL_W-1:0] : list_size_r;
  assign cfg_prdata = (cfg_paddr[2] == REG_LIST_SIZE) ? DATA_W'(list_size_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_size_r <= LIST_SIZE_RST;
    end else begin
      list_size_r <= list_size_nxt;
    end
  end

  rlsf_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_action (in_action),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rlsf_dp #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .list_size      (list_size_r),
    .in_first_value (in_first_value),
    .in_last_value  (in_last_value),
    .cmd            (cmd),
    .sts            (sts),
    .out_value      (out_value),
    .out_is_last    (out_is_last),
    .out_skipped    (out_skipped)
  );

endmodule

/* hdl/rlsf_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlsf_ctrl
// Sequencer: accepts one word at a time, steps build, move and walk
// through the datapath and loads the result word when the output is free.
// ----------------------------------------------------------------------------
module rlsf_ctrl (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [rlsf_pkg::ACT_W-1:0] in_action,
  output logic                      out_valid,
  input  logic                      out_ready,
  input  rlsf_pkg::sts_t            sts,
  output rlsf_pkg::cmd_t            cmd
);
  import rlsf_pkg::*;

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_BLD    = 4'd1;
  localparam logic [3:0] ST_MV_RD  = 4'd2;
  localparam logic [3:0] ST_MV_W1  = 4'd3;
  localparam logic [3:0] ST_MV_W2  = 4'd4;
  localparam logic [3:0] ST_MV_W3  = 4'd5;
  localparam logic [3:0] ST_WK_RD  = 4'd6;
  localparam logic [3:0] ST_FIN_WK = 4'd7;
  localparam logic [3:0] ST_FIN    = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       skip_r, skip_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    skip_nxt  = skip_r;
    cmd       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          skip_nxt   = 1'b0;
          unique case (in_action)
            ACT_BUILD: begin
              cmd.bld_start = 1'b1;
              state_nxt     = ST_BLD;
            end
            ACT_MOVE: begin
              if (!sts.mv_ok) begin
                state_nxt = ST_FIN;
              end else if (sts.mv_head) begin
                skip_nxt     = 1'b1;
                cmd.cur_head = 1'b1;
                state_nxt    = ST_FIN;
              end else begin
                state_nxt = ST_MV_RD;
              end
            end
            ACT_WALK: begin
              state_nxt = ST_WK_RD;
            end
            default: begin
              state_nxt = ST_FIN;
            end
          endcase
        end
      end
      ST_BLD: begin
        cmd.bld_wr = 1'b1;
        if (sts.bld_last) begin
          state_nxt = ST_FIN;
        end
      end
      ST_MV_RD: begin
        cmd.mv_rd = 1'b1;
        state_nxt = ST_MV_W1;
      end
      ST_MV_W1: begin
        cmd.mv_w1 = 1'b1;
        state_nxt = ST_MV_W2;
      end
      ST_MV_W2: begin
        cmd.mv_w2 = 1'b1;
        state_nxt = ST_MV_W3;
      end
      ST_MV_W3: begin
        cmd.mv_w3 = 1'b1;
        state_nxt = ST_FIN;
      end
      ST_WK_RD: begin
        cmd.wk_rd = 1'b1;
        state_nxt = ST_FIN_WK;
      end
      ST_FIN_WK: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_walk = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      ST_FIN: begin
        if (out_free) begin
          cmd.res_load = 1'b1;
          cmd.res_skip = skip_r;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      skip_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      skip_r      <= skip_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

/* hdl/rlsf_dp.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rlsf_dp
// Datapath: next and prev pointer tables, head, walk cursor, build counter
// and the result word register.
// ----------------------------------------------------------------------------
module rlsf_dp #(
  parameter int unsigned MAX_ITEMS = rlsf_pkg::MAX_ITEMS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic [rlsf_pkg::VAL_W-1:0] list_size,
  input  logic [rlsf_pkg::VAL_W-1:0] in_first_value,
  input  logic [rlsf_pkg::VAL_W-1:0] in_last_value,
  input  rlsf_pkg::cmd_t             cmd,
  output rlsf_pkg::sts_t             sts,
  output logic [rlsf_pkg::VAL_W-1:0] out_value,
  output logic                       out_is_last,
  output logic                       out_skipped
);
  import rlsf_pkg::*;

  localparam int unsigned IDX_W  = (MAX_ITEMS > 1) ? $clog2(MAX_ITEMS) : 1;
  localparam int unsigned WIDE_W = (IDX_W > VAL_W) ? IDX_W : VAL_W;
  localparam int unsigned NCAP   = (MAX_ITEMS > VAL_MAX) ? VAL_MAX : MAX_ITEMS;
  localparam logic [VAL_W-1:0] NCAP_V      = VAL_W'(NCAP);
  localparam logic [31:0]      MAX_ITEMS_U = 32'(MAX_ITEMS);

  function automatic logic [IDX_W-1:0] to_idx(input logic [VAL_W-1:0] v);
    logic [VAL_W-1:0]  vm;
    logic [WIDE_W-1:0] w;
    vm = v - VAL_ONE;
    w  = WIDE_W'(vm);
    return w[IDX_W-1:0];
  endfunction

  function automatic logic in_tbl(input logic [VAL_W-1:0] v);
    return (v != '0) && (32'(v) <= MAX_ITEMS_U);
  endfunction

  logic [VAL_W-1:0] next_mem [MAX_ITEMS];
  logic [VAL_W-1:0] prev_mem [MAX_ITEMS];

  logic [VAL_W-1:0] list_n;
  logic [VAL_W-1:0] head_r, head_nxt;
  logic [VAL_W-1:0] cursor_r, cursor_nxt;
  logic [VAL_W-1:0] bld_cnt_r, bld_cnt_nxt;
  logic [VAL_W-1:0] first_r, last_r;
  logic [VAL_W-1:0] e_r;
  logic [VAL_W-1:0] next_rd_r, prev_rd_a_r, prev_rd_b_r;
  logic [VAL_W-1:0] out_value_r;
  logic             out_last_r, out_skip_r;

  logic             next_we, prev_we;
  logic [VAL_W-1:0] next_wa, next_wd, prev_wa, prev_wd;
  logic             next_re;
  logic [VAL_W-1:0] next_ra;

  always_comb begin
    if (list_size == '0) begin
      list_n = VAL_ONE;
    end else if (list_size > NCAP_V) begin
      list_n = NCAP_V;
    end else begin
      list_n = list_size;
    end
  end

  assign sts.mv_ok    = (in_first_value != '0) && (in_first_value <= list_n) &&
                        (in_last_value != '0) && (in_last_value <= list_n);
  assign sts.mv_head  = (in_first_value == head_r);
  assign sts.bld_last = (bld_cnt_r == list_n);

  // pointer writes, one per table per cycle
  always_comb begin
    priority if (cmd.mv_w1) begin
      next_wa = prev_rd_a_r;
      next_wd = next_rd_r;
      prev_wa = next_rd_r;
      prev_wd = prev_rd_a_r;
    end else if (cmd.mv_w2) begin
      next_wa = e_r;
      next_wd = first_r;
      prev_wa = first_r;
      prev_wd = e_r;
    end else if (cmd.mv_w3) begin
      next_wa = last_r;
      next_wd = head_r;
      prev_wa = head_r;
      prev_wd = last_r;
    end else begin
      next_wa = bld_cnt_r;
      next_wd = (bld_cnt_r == list_n) ? VAL_ONE : bld_cnt_r + VAL_ONE;
      prev_wa = bld_cnt_r;
      prev_wd = (bld_cnt_r == VAL_ONE) ? list_n : bld_cnt_r - VAL_ONE;
    end
    next_we = (cmd.bld_wr || cmd.mv_w1 || cmd.mv_w2 || cmd.mv_w3) && in_tbl(next_wa);
    prev_we = (cmd.bld_wr || cmd.mv_w1 || cmd.mv_w2 || cmd.mv_w3) && in_tbl(prev_wa);
  end

  assign next_re = cmd.mv_rd || cmd.wk_rd;
  assign next_ra = cmd.wk_rd ? cursor_r : last_r;

  always_ff @(posedge clk) begin
    if (next_we) begin
      next_mem[to_idx(next_wa)] <= next_wd;
    end
    if (next_re) begin
      next_rd_r <= next_mem[to_idx(next_ra)];
    end
  end

  always_ff @(posedge clk) begin
    if (prev_we) begin
      prev_mem[to_idx(prev_wa)] <= prev_wd;
    end
    if (cmd.mv_rd) begin
      prev_rd_a_r <= prev_mem[to_idx(first_r)];
      prev_rd_b_r <= prev_mem[to_idx(head_r)];
    end
  end

  always_comb begin
    head_nxt    = head_r;
    cursor_nxt  = cursor_r;
    bld_cnt_nxt = bld_cnt_r;
    if (cmd.bld_start) begin
      head_nxt    = VAL_ONE;
      cursor_nxt  = VAL_ONE;
      bld_cnt_nxt = VAL_ONE;
    end
    if (cmd.bld_wr) begin
      bld_cnt_nxt = bld_cnt_r + VAL_ONE;
    end
    if (cmd.cur_head) begin
      cursor_nxt = head_r;
    end
    if (cmd.mv_w3) begin
      head_nxt   = first_r;
      cursor_nxt = first_r;
    end
    if (cmd.res_load && cmd.res_walk) begin
      cursor_nxt = next_rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r    <= VAL_ONE;
      cursor_r  <= VAL_ONE;
      bld_cnt_r <= VAL_ONE;
    end else begin
      head_r    <= head_nxt;
      cursor_r  <= cursor_nxt;
      bld_cnt_r <= bld_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      first_r <= in_first_value;
      last_r  <= in_last_value;
    end
    // forward the step-one prev write when it hits the head
    if (cmd.mv_w1) begin
      e_r <= (next_rd_r == head_r) ? prev_rd_a_r : prev_rd_b_r;
    end
    if (cmd.res_load) begin
      out_value_r <= cmd.res_walk ? cursor_r : '0;
      out_last_r  <= cmd.res_walk && (next_rd_r == head_r);
      out_skip_r  <= cmd.res_skip;
    end
  end

  assign out_value   = out_value_r;
  assign out_is_last = out_last_r;
  assign out_skipped = out_skip_r;

  a_head_src: assert property (@(posedge clk) disable iff (!rst_n)
    ($past(rst_n) && !$stable(head_r)) |-> $past(cmd.mv_w3 || cmd.bld_start))
    else $error("head changed outside move commit or build start");

  a_bld_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.bld_wr |-> (bld_cnt_r != '0) && (bld_cnt_r <= list_n))
    else $error("build counter out of range");

  a_wr_phase: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.bld_wr, cmd.mv_w1, cmd.mv_w2, cmd.mv_w3, cmd.res_load}))
    else $error("overlapping datapath phases");

endmodule
